// ===== hw/rtl/pulse_code_passcode_detector_macros.svh =====
`ifndef PULSE_CODE_PASSCODE_DETECTOR_MACROS_SVH
`define PULSE_CODE_PASSCODE_DETECTOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define PCPD_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define PCPD_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/pcpd_pkg.sv =====
package pcpd_pkg;

    localparam int unsigned LEVEL_W   = 12;
    localparam int unsigned TICK_W    = 8;
    localparam int unsigned PATTERN_W = 40;
    localparam int unsigned CFG_IDX_W = 3;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EDGE_DELTA      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DASH_TICKS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GAP_TICKS       = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_PATTERN    = 3'd4;

    // Register reset values
    localparam logic [LEVEL_W-1:0]   RST_LEVEL_THRESHOLD = 12'd2000;
    localparam logic [LEVEL_W-1:0]   RST_EDGE_DELTA      = 12'd2000;
    localparam logic [TICK_W-1:0]    RST_DASH_TICKS      = 8'd6;
    localparam logic [TICK_W-1:0]    RST_GAP_TICKS       = 8'd12;
    localparam logic [PATTERN_W-1:0] RST_CODE_PATTERN    = 40'd735946635093;

    // Symbol codes
    localparam logic [1:0] SYM_NONE = 2'd0;
    localparam logic [1:0] SYM_DOT  = 2'd1;
    localparam logic [1:0] SYM_DASH = 2'd2;
    localparam logic [1:0] SYM_GAP  = 2'd3;

    localparam logic [TICK_W-1:0] TICK_MAX = 8'hFF;

    typedef struct packed {
        logic [LEVEL_W-1:0]   level_threshold;
        logic [LEVEL_W-1:0]   edge_delta;
        logic [TICK_W-1:0]    dash_ticks;
        logic [TICK_W-1:0]    gap_ticks;
        logic [PATTERN_W-1:0] code_pattern;
    } cfg_t;

    typedef struct packed {
        logic match_now;
        logic toggle_pulse;
    } res_t;

endpackage

// ===== hw/rtl/pulse_code_passcode_detector.sv =====
// Channel   Direction  Handshake                Payload
// s_        in         s_valid / s_ready        s_sample
// m_        out        m_valid / m_ready        m_match_now, m_toggle_pulse
// cfg_      in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// One sample per clock while s_ready is high; its result is captured in the output register as the sample is taken.
// Throughput is set by the single registered update of the symbol window per sample.
// Reset (aresetn low, synchronous) restores all registers but the output payload to their defaults.
// A stalled output holds its item; s_ready stays high while that item is being taken.
// cfg_ready is always high; writes take effect on the next sample.
module pulse_code_passcode_detector #(
    parameter int unsigned WINDOW_SYMBOLS = 20,
    parameter int unsigned SAMPLE_BITS    = 12
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [SAMPLE_BITS-1:0]         s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic                           m_match_now,
    output logic                           m_toggle_pulse,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [pcpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [pcpd_pkg::PATTERN_W-1:0] cfg_data
);
    import pcpd_pkg::*;

    cfg_t cfg;
    res_t res;
    res_t res_reg;
    logic m_valid_reg;
    logic take;

    assign cfg_ready = 1'b1;
    assign s_ready   = !m_valid_reg || m_ready;
    assign take      = s_valid && s_ready;

    pcpd_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    pcpd_core #(
        .WINDOW_SYMBOLS (WINDOW_SYMBOLS),
        .SAMPLE_BITS    (SAMPLE_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .sample  (s_sample),
        .cfg     (cfg),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Payload needs no reset
    always_ff @(posedge aclk) begin
        if (take) begin
            res_reg <= res;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_match_now    = res_reg.match_now;
    assign m_toggle_pulse = res_reg.toggle_pulse;

endmodule

// ===== hw/rtl/pcpd_cfg.sv =====
module pcpd_cfg (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           wr_en,
    input  logic [pcpd_pkg::CFG_IDX_W-1:0] wr_index,
    input  logic [pcpd_pkg::PATTERN_W-1:0] wr_data,
    output pcpd_pkg::cfg_t                 cfg
);
    import pcpd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.level_threshold <= RST_LEVEL_THRESHOLD;
            cfg_reg.edge_delta      <= RST_EDGE_DELTA;
            cfg_reg.dash_ticks      <= RST_DASH_TICKS;
            cfg_reg.gap_ticks       <= RST_GAP_TICKS;
            cfg_reg.code_pattern    <= RST_CODE_PATTERN;
        end else if (wr_en) begin
            unique case (wr_index)
                CFG_LEVEL_THRESHOLD: cfg_reg.level_threshold <= wr_data[LEVEL_W-1:0];
                CFG_EDGE_DELTA:      cfg_reg.edge_delta      <= wr_data[LEVEL_W-1:0];
                CFG_DASH_TICKS:      cfg_reg.dash_ticks      <= wr_data[TICK_W-1:0];
                CFG_GAP_TICKS:       cfg_reg.gap_ticks       <= wr_data[TICK_W-1:0];
                CFG_CODE_PATTERN:    cfg_reg.code_pattern    <= wr_data;
                default: begin
                    // unknown index: drop the write
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== hw/rtl/pcpd_core.sv =====
`include "pulse_code_passcode_detector_macros.svh"

module pcpd_core #(
    parameter int unsigned WINDOW_SYMBOLS = 20,
    parameter int unsigned SAMPLE_BITS    = 12
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   take,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  pcpd_pkg::cfg_t         cfg,
    output pcpd_pkg::res_t         res
);
    import pcpd_pkg::*;

    localparam int unsigned WW     = 2 * WINDOW_SYMBOLS;
    localparam int unsigned SEEN_W = $clog2(WINDOW_SYMBOLS + 2);
    localparam int unsigned CMP_W  = ((SAMPLE_BITS > LEVEL_W) ? SAMPLE_BITS : LEVEL_W) + 1;
    localparam int unsigned PAT_XW = (WW > PATTERN_W) ? WW : PATTERN_W;
    localparam logic [SEEN_W-1:0] SEEN_MAX = SEEN_W'(WINDOW_SYMBOLS + 1);
    localparam logic [SEEN_W-1:0] SEEN_FULL = SEEN_W'(WINDOW_SYMBOLS);

    logic [SAMPLE_BITS-1:0] level_now_reg;
    logic [TICK_W-1:0]      ticks_reg,  ticks_next;
    logic [WW-1:0]          window_reg, window_next;
    logic                   gap_reg,    gap_next;
    logic [SEEN_W-1:0]      seen_reg,   seen_next;
    logic                   held_reg;

    logic [CMP_W-1:0]  samp_c, prev_c, thr_c, delta_c;
    logic              rise, fall, level_high, level_low;
    logic [TICK_W-1:0] ticks_eff;
    logic [WW-1:0]     win_gap, win_open, win_edge;
    logic [SEEN_W:0]   seen_sum;
    logic [1:0]        seen_inc;
    logic [1:0]        sym_code;
    logic [PAT_XW-1:0] pat_ext;
    logic              match;

    always_comb begin
        samp_c  = CMP_W'(sample);
        prev_c  = CMP_W'(level_now_reg);
        thr_c   = CMP_W'(cfg.level_threshold);
        delta_c = CMP_W'(cfg.edge_delta);

        rise       = samp_c > (prev_c + delta_c);
        fall       = prev_c > (samp_c + delta_c);
        level_high = samp_c > thr_c;
        level_low  = samp_c < thr_c;

        ticks_eff = (rise || fall) ? '0 : ticks_reg;

        // A rising edge commits a pending gap, then opens an empty slot
        win_gap  = gap_reg ? {SYM_GAP, window_reg[WW-1:2]} : window_reg;
        win_open = {SYM_NONE, win_gap[WW-1:2]};
        win_edge = rise ? win_open : window_reg;

        seen_inc = rise ? (gap_reg ? 2'd2 : 2'd1) : 2'd0;
        seen_sum = {1'b0, seen_reg} + (SEEN_W + 1)'(seen_inc);
        seen_next = (seen_sum > (SEEN_W + 1)'(SEEN_MAX)) ? SEEN_MAX : seen_sum[SEEN_W-1:0];

        sym_code = (ticks_eff > cfg.dash_ticks) ? SYM_DASH : SYM_DOT;
        if (level_high && seen_next != '0) begin
            window_next = {sym_code, win_edge[WW-3:0]};
        end else begin
            window_next = win_edge;
        end

        gap_next = (level_low && ticks_eff > cfg.gap_ticks) ? 1'b1 : (gap_reg && !rise);

        ticks_next = (ticks_eff == TICK_MAX) ? ticks_eff : ticks_eff + 1'b1;

        pat_ext = PAT_XW'(cfg.code_pattern);
        match   = (seen_next > SEEN_FULL) && (window_next == pat_ext[WW-1:0]);

        res.match_now    = match;
        res.toggle_pulse = match && !held_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_now_reg <= '0;
            ticks_reg     <= '0;
            window_reg    <= '0;
            gap_reg       <= 1'b0;
            seen_reg      <= '0;
            held_reg      <= 1'b0;
        end else if (take) begin
            level_now_reg <= sample;
            ticks_reg     <= ticks_next;
            window_reg    <= window_next;
            gap_reg       <= gap_next;
            seen_reg      <= seen_next;
            held_reg      <= match;
        end
    end

    `PCPD_ASSERT_NOW(a_seen_sat, aclk, aresetn, 1'b1, seen_reg <= SEEN_MAX, "slot count overran")
    `PCPD_ASSERT_NEXT(a_edge_clears_ticks, aclk, aresetn, take && (rise || fall),
        ticks_reg == TICK_W'(1), "edge did not restart tick count")
    `PCPD_ASSERT_NEXT(a_rise_clears_gap, aclk, aresetn, take && rise, !gap_reg,
        "gap still pending after rising edge")
    `PCPD_ASSERT_NEXT(a_pulse_then_held, aclk, aresetn, take && res.toggle_pulse, held_reg,
        "match not held after pulse")

endmodule

// ===== tb/sv/pulse_code_passcode_detector_tb.sv =====
`timescale 1ns / 1ps

module pulse_code_passcode_detector_tb;
    import pcpd_pkg::*;

    localparam int SYMBOLS = 20;
    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_UNUSED = CFG_CODE_PATTERN + 1'b1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_UNUSED  = '1;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    logic [LEVEL_W-1:0]   s_sample  = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    logic                 m_match_now;
    logic                 m_toggle_pulse;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [PATTERN_W-1:0] cfg_data  = '0;

    pulse_code_passcode_detector dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_sample       (s_sample),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_match_now    (m_match_now),
        .m_toggle_pulse (m_toggle_pulse),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Register copies
    logic [LEVEL_W-1:0]   thr_set   = RST_LEVEL_THRESHOLD;
    logic [LEVEL_W-1:0]   delta_set = RST_EDGE_DELTA;
    logic [TICK_W-1:0]    dash_set  = RST_DASH_TICKS;
    logic [TICK_W-1:0]    gap_set   = RST_GAP_TICKS;
    logic [PATTERN_W-1:0] code_set  = RST_CODE_PATTERN;

    // Detector state
    logic [LEVEL_W-1:0]   cur_level    = '0;
    logic [LEVEL_W-1:0]   prev_level   = '0;
    logic [TICK_W-1:0]    since_edge   = '0;
    logic [PATTERN_W-1:0] window       = '0;
    logic                 gap_armed    = 1'b0;
    logic [4:0]           slots_opened = '0;
    logic                 match_before = 1'b0;

    res_t expected_flags[$];
    int   mismatches = 0;
    bit   idle_on    = 1'b0;

    // Level bands for shaped symbol trains
    int low_min, low_max, mid_min, mid_max, high_min, high_max;

    function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                        input logic [PATTERN_W-1:0] data);
        case (idx)
            CFG_LEVEL_THRESHOLD: thr_set = data[LEVEL_W-1:0];
            CFG_EDGE_DELTA:      delta_set = data[LEVEL_W-1:0];
            CFG_DASH_TICKS:      dash_set = data[TICK_W-1:0];
            CFG_GAP_TICKS:       gap_set = data[TICK_W-1:0];
            CFG_CODE_PATTERN:    code_set = data;
            default: ;
        endcase
    endfunction

    function automatic void push_symbol(input logic [1:0] sym);
        window = {sym, window[PATTERN_W-1:2]};
        if (slots_opened <= SYMBOLS)
            slots_opened++;
    endfunction

    function automatic res_t step_detector(input logic [LEVEL_W-1:0] smp);
        int   rise;
        res_t r;
        prev_level = cur_level;
        cur_level  = smp;
        rise = int'(cur_level) - int'(prev_level);
        if (rise > int'(delta_set)) begin
            since_edge = '0;
            // commit the pending letter gap ahead of the new slot
            if (gap_armed) begin
                push_symbol(SYM_GAP);
                gap_armed = 1'b0;
            end
            push_symbol(SYM_NONE);
        end
        if (-rise > int'(delta_set))
            since_edge = '0;
        if (cur_level > thr_set && slots_opened != 0)
            window[PATTERN_W-1 -: 2] = (since_edge > dash_set) ? SYM_DASH : SYM_DOT;
        if (cur_level < thr_set && since_edge > gap_set)
            gap_armed = 1'b1;
        r.match_now    = (slots_opened > SYMBOLS) && (window == code_set);
        r.toggle_pulse = r.match_now && !match_before;
        match_before   = r.match_now;
        if (since_edge != TICK_MAX)
            since_edge++;
        return r;
    endfunction

    // Writes first, then the new item, then the result leaving
    always @(posedge aclk) begin : monitor
        res_t want;
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                apply_write(cfg_index, cfg_data);
            if (s_valid && s_ready)
                expected_flags.push_back(step_detector(s_sample));
            if (m_valid && m_ready) begin
                if (expected_flags.size() == 0) begin
                    $display("%0t: result with no item outstanding (match_now %0b, toggle_pulse %0b)",
                             $time, m_match_now, m_toggle_pulse);
                    mismatches++;
                end else begin
                    want = expected_flags.pop_front();
                    if (m_match_now !== want.match_now) begin
                        $display("%0t: match_now expected %0b, got %0b",
                                 $time, want.match_now, m_match_now);
                        mismatches++;
                    end
                    if (m_toggle_pulse !== want.toggle_pulse) begin
                        $display("%0t: toggle_pulse expected %0b, got %0b",
                                 $time, want.toggle_pulse, m_toggle_pulse);
                        mismatches++;
                    end
                end
            end
        end
    end

    function automatic int pause_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    always @(negedge aclk) begin : sink
        static int hold_off = 0;
        if (hold_off > 0) begin
            hold_off--;
            m_ready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 3) == 0) begin
            hold_off = pause_len() - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_sample(input logic [LEVEL_W-1:0] v);
        int gap;
        gap = (idle_on && $urandom_range(0, 2) == 0) ? pause_len() : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid  <= 1'b1;
        s_sample <= v;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PATTERN_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Junk above each field checks that narrow registers drop the upper bits
    task automatic program_detector(input logic [LEVEL_W-1:0] thr, input logic [LEVEL_W-1:0] delta,
                                    input logic [TICK_W-1:0] dash, input logic [TICK_W-1:0] gap,
                                    input logic [PATTERN_W-1:0] code);
        logic [PATTERN_W-1:0] junk;
        junk = {8'($urandom), $urandom};
        write_reg(CFG_LEVEL_THRESHOLD, {junk[PATTERN_W-1:LEVEL_W], thr});
        junk = {8'($urandom), $urandom};
        write_reg(CFG_EDGE_DELTA, {junk[PATTERN_W-1:LEVEL_W], delta});
        junk = {8'($urandom), $urandom};
        write_reg(CFG_DASH_TICKS, {junk[PATTERN_W-1:TICK_W], dash});
        junk = {8'($urandom), $urandom};
        write_reg(CFG_GAP_TICKS, {junk[PATTERN_W-1:TICK_W], gap});
        write_reg(CFG_CODE_PATTERN, code);
    endtask

    // Hold the sender until every result is back, then let the pipeline empty
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_flags.size() != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic use_levels(input int lo_a, input int lo_b, input int mi_a, input int mi_b,
                              input int hi_a, input int hi_b);
        low_min  = lo_a;
        low_max  = lo_b;
        mid_min  = mi_a;
        mid_max  = mi_b;
        high_min = hi_a;
        high_max = hi_b;
    endtask

    task automatic send_low(input int n);
        repeat (n) send_sample(12'($urandom_range(low_min, low_max)));
    endtask

    task automatic send_mid(input int n);
        repeat (n) send_sample(12'($urandom_range(mid_min, mid_max)));
    endtask

    task automatic send_high(input int n);
        repeat (n) send_sample(12'($urandom_range(high_min, high_max)));
    endtask

    task automatic send_noise(input int n);
        logic [LEVEL_W-1:0] v;
        repeat (n) begin
            case ($urandom_range(0, 3))
                0: v = thr_set + 12'($urandom_range(0, 2)) - 12'd1;
                1: v = $urandom_range(0, 1) ? '1 : '0;
                default: v = 12'($urandom_range(0, 4095));
            endcase
            send_sample(v);
        end
    endtask

    // One symbol slot: a low stretch, a rising edge, then the high part (a single mid-band sample for an empty slot)
    task automatic emit_slot(input logic [1:0] sym, input bit long_low);
        if (long_low)
            send_low(int'(gap_set) + 2 + $urandom_range(0, 3));
        else
            send_low($urandom_range(1, int'(gap_set) + 1));
        case (sym)
            SYM_DOT:  send_high($urandom_range(1, int'(dash_set) + 1));
            SYM_DASH: send_high(int'(dash_set) + 2 + $urandom_range(0, 3));
            default:  send_sample(12'($urandom_range(mid_min, mid_max)));
        endcase
    endtask

    task automatic emit_code(input logic [PATTERN_W-1:0] code);
        bit long_low;
        long_low = 1'b0;
        for (int k = 0; k < SYMBOLS; k++) begin
            if (code[2*k +: 2] == SYM_GAP) begin
                long_low = 1'b1;
            end else begin
                emit_slot(code[2*k +: 2], long_low);
                long_low = 1'b0;
            end
        end
    endtask

    // Gaps never sit side by side and never stand newest
    function automatic logic [PATTERN_W-1:0] gen_code(input bit allow_none);
        logic [PATTERN_W-1:0] code;
        logic [1:0]           sym;
        logic [1:0]           prev;
        code = '0;
        prev = SYM_NONE;
        for (int k = 0; k < SYMBOLS; k++) begin
            do sym = 2'($urandom_range(0, 3));
            while ((sym == SYM_NONE && !allow_none) ||
                   (sym == SYM_GAP && (k == SYMBOLS - 1 || prev == SYM_GAP)));
            code[2*k +: 2] = sym;
            prev = sym;
        end
        return code;
    endfunction

    task automatic test_directed();
        idle_on = 1'b0;
        // long low before any edge still arms a gap
        for (int k = 0; k < 14; k++)
            send_sample(k[0] ? 12'd1999 : 12'd0);
        send_sample(12'd3000);
        send_sample(12'd0);
        send_sample(12'd4095);
        send_sample(12'd2000);
        send_sample(12'd4095);
        send_sample(12'd4095);
        send_sample(12'd2095);
        send_sample(12'd95);
        send_sample(12'd2096);
        // hold high across the reset dash length
        repeat (8) send_sample(12'd4095);
        settle();
    endtask

    task automatic test_default_code();
        idle_on = 1'b1;
        use_levels(0, 900, 0, 0, 3000, 4095);
        // shorten the symbols, keep the pattern from reset
        write_reg(CFG_DASH_TICKS, 40'd1);
        write_reg(CFG_GAP_TICKS, 40'd2);
        emit_slot(SYM_DOT, 1'b0);
        emit_code(RST_CODE_PATTERN);
        send_low(5);
        emit_slot(SYM_DASH, 1'b0);
        settle();
    endtask

    // The middle band sits within edge_delta of the high band, so the count runs on
    task automatic test_tick_saturation();
        idle_on = 1'b1;
        use_levels(0, 900, 1500, 1900, 2100, 2400);
        program_detector(RST_LEVEL_THRESHOLD, 12'd1000, 8'd255, 8'd255, RST_CODE_PATTERN);
        send_low(2);
        send_high(258);
        send_mid(3);
        settle();
        program_detector(RST_LEVEL_THRESHOLD, 12'd1000, 8'd254, 8'd254, RST_CODE_PATTERN);
        send_high(3);
        send_mid(3);
        send_low(2);
        send_high(2);
        settle();
    endtask

    task automatic test_register_extremes();
        idle_on = 1'b1;
        program_detector('0, '0, '0, '0, '0);
        send_noise(12);
        settle();
        // nothing is ever high and every rise opens an empty slot
        program_detector('1, '0, '0, '0, '0);
        for (int k = 0; k < 16; k++)
            send_sample(k[0] ? 12'($urandom_range(1, 4095)) : 12'd0);
        settle();
        program_detector('1, '1, '1, '1, '1);
        send_noise(12);
        settle();
        for (logic [CFG_IDX_W:0] idx = CFG_FIRST_UNUSED; idx <= CFG_LAST_UNUSED; idx++)
            write_reg(idx[CFG_IDX_W-1:0], {8'($urandom), $urandom});
        send_noise(8);
        settle();
    endtask

    task automatic test_random_codes();
        logic [PATTERN_W-1:0] code;
        logic [PATTERN_W-1:0] sent;
        int                   k;
        for (int round = 0; round < 2; round++) begin
            code = gen_code(1'b1);
            if (round[0] == 1'b0) begin
                program_detector(12'd1000, 12'd300, 8'($urandom_range(0, 2)),
                                 8'($urandom_range(0, 2)), code);
                use_levels(0, 200, 600, 1000, 1500, 1700);
            end else begin
                program_detector(12'd2048, 12'd100, 8'($urandom_range(0, 2)),
                                 8'($urandom_range(0, 2)), code);
                use_levels(0, 100, 300, 2048, 3000, 3100);
            end
            idle_on = (round != 1);
            repeat ($urandom_range(1, 2)) emit_slot(SYM_DOT, 1'b0);
            sent = code;
            // break one symbol now and then
            if ($urandom_range(0, 3) == 0) begin
                k = $urandom_range(0, SYMBOLS - 1);
                sent[2*k +: 2] = sent[2*k +: 2] ^ 2'($urandom_range(1, 3));
            end
            emit_code(sent);
            if ($urandom_range(0, 4) == 0)
                send_noise(5);
            send_low($urandom_range(1, 10));
            emit_slot(SYM_DASH, 1'b0);
            settle();
        end
    endtask

    task automatic test_random_noise();
        repeat (2) begin
            program_detector(12'($urandom), 12'($urandom), 8'($urandom), 8'($urandom),
                             {8'($urandom), $urandom});
            idle_on = $urandom_range(0, 1);
            send_noise(12);
            settle();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_default_code();
        test_tick_saturation();
        test_register_extremes();
        test_random_codes();
        test_random_noise();
        settle();
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
